// ===== design/framed_csv_integer_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the framed CSV integer parser.
// ----------------------------------------------------------------------------
`ifndef FRAMED_CSV_INTEGER_PARSER_CORE_MACROS_SVH
`define FRAMED_CSV_INTEGER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FCIP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FCIP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fcip_pkg.sv =====
// ----------------------------------------------------------------------------
// fcip_pkg
// Types and constants for the framed CSV integer parser.
// ----------------------------------------------------------------------------
package fcip_pkg;

	localparam int VALUE_SLOTS = 6;
	localparam int VALUE_W     = 16;
	localparam int COUNT_W     = 3;
	localparam int REG_IDX_W   = 2;

	// Register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_START     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_END = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_END = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SEPARATOR = 2'd3;

	// Register reset values
	localparam logic [7:0] START_RST      = 8'h40;
	localparam logic [7:0] FIRST_END_RST  = 8'h23;
	localparam logic [7:0] SECOND_END_RST = 8'h24;
	localparam logic [7:0] SEPARATOR_RST  = 8'h2c;

	// Character codes
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef logic [VALUE_SLOTS-1:0][VALUE_W-1:0] fcip_values_t;

	// Control from the frame sequencer to the token decoder
	typedef struct packed {
		logic clear;   // frame opened
		logic feed;    // payload byte to parse
		logic sep;     // fed byte is the separator
		logic finish;  // frame completed
	} fcip_tok_ctl_t;

	typedef struct packed {
		fcip_values_t       values;
		logic [COUNT_W-1:0] tokens_found;
		logic               complete;
	} fcip_result_t;

endpackage

// ===== design/framed_csv_integer_parser_core.sv =====
// ----------------------------------------------------------------------------
// framed_csv_integer_parser_core
// Framed comma-separated decimal parser: one byte per beat, six values per
// frame.
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid / rx_ready  rx_byte
//   res      out        res_valid/res_ready  value_zero..value_five,
//                                            tokens_found, complete
//   cfg      in         cfg_we               cfg_index, cfg_data
//
// One byte is taken per cycle while the skid entry is empty; a byte updates
// frame and token state in the cycle it is accepted. The frame-end byte places
// its result in the output register on that same edge when the register is
// free, visible the next cycle; otherwise the result waits in the skid entry
// behind it. The skid entry keeps rx_ready high while one result waits in the
// output register; rx_ready drops only while that skid entry is occupied.
// Reset loads the register defaults and clears all state but the result data.
// ----------------------------------------------------------------------------
module framed_csv_integer_parser_core
	import fcip_pkg::*;
#(
	parameter int PAYLOAD_CAPACITY = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic [7:0]           rx_byte,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [VALUE_W-1:0]   value_zero,
	output logic [VALUE_W-1:0]   value_one,
	output logic [VALUE_W-1:0]   value_two,
	output logic [VALUE_W-1:0]   value_three,
	output logic [VALUE_W-1:0]   value_four,
	output logic [VALUE_W-1:0]   value_five,
	output logic [COUNT_W-1:0]   tokens_found,
	output logic                 complete,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam int LEN_W = $clog2(PAYLOAD_CAPACITY + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PAYLOAD,
		PH_TRAILER
	} frame_phase_t;

	frame_phase_t       phase_q, phase_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic               text_ended_q, text_ended_n;
	logic [7:0]         start_q, first_end_q, second_end_q, separator_q;
	logic               rx_fire, emit, queue_full;
	fcip_tok_ctl_t      tok_ctl;
	fcip_values_t       store_next;
	logic [COUNT_W-1:0] count_next;
	fcip_result_t       result, res_data;
	logic               res_count_full;

	assign rx_ready = !queue_full;
	assign rx_fire  = rx_valid && rx_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= START_RST;
			first_end_q  <= FIRST_END_RST;
			second_end_q <= SECOND_END_RST;
			separator_q  <= SEPARATOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START:      start_q      <= cfg_data;
				REG_FIRST_END:  first_end_q  <= cfg_data;
				REG_SECOND_END: second_end_q <= cfg_data;
				REG_SEPARATOR:  separator_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_n      = phase_q;
		len_n        = len_q;
		text_ended_n = text_ended_q;
		tok_ctl      = '0;
		emit         = 1'b0;
		if (rx_fire) begin
			case (phase_q)
				PH_IDLE: begin
					if (rx_byte == start_q) begin
						tok_ctl.clear = 1'b1;
						phase_n       = PH_PAYLOAD;
						len_n         = '0;
						text_ended_n  = 1'b0;
					end
				end
				PH_PAYLOAD: begin
					if (rx_byte == first_end_q) begin
						phase_n = PH_TRAILER;
					end else if (len_q < LEN_W'(PAYLOAD_CAPACITY)) begin
						len_n = len_q + LEN_W'(1);
						if (!text_ended_q) begin
							// NUL stops parsing for the rest of the frame
							if (rx_byte == CHAR_NUL) begin
								text_ended_n = 1'b1;
							end else begin
								tok_ctl.feed = 1'b1;
								tok_ctl.sep  = (rx_byte == separator_q);
							end
						end
					end
				end
				PH_TRAILER: begin
					if (rx_byte == second_end_q) begin
						tok_ctl.finish = 1'b1;
						emit           = 1'b1;
						phase_n        = PH_IDLE;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			len_q        <= '0;
			text_ended_q <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			len_q        <= len_n;
			text_ended_q <= text_ended_n;
		end
	end

	fcip_token u_token (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (tok_ctl),
		.data       (rx_byte),
		.store_next (store_next),
		.count_next (count_next)
	);

	assign result.values       = store_next;
	assign result.tokens_found = count_next;
	assign result.complete     = (count_next == COUNT_W'(VALUE_SLOTS));

	fcip_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (result),
		.full      (queue_full),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_data  (res_data)
	);

	assign value_zero   = res_data.values[0];
	assign value_one    = res_data.values[1];
	assign value_two    = res_data.values[2];
	assign value_three  = res_data.values[3];
	assign value_four   = res_data.values[4];
	assign value_five   = res_data.values[5];
	assign tokens_found = res_data.tokens_found;
	assign complete     = res_data.complete;

	assign res_count_full = (tokens_found == COUNT_W'(VALUE_SLOTS));

`include "framed_csv_integer_parser_core_macros.svh"

	`FCIP_ASSERT_IMP(a_count_range, res_valid, tokens_found <= COUNT_W'(VALUE_SLOTS), "count above six")
	`FCIP_ASSERT_IMP(a_complete_flag, res_valid, complete == res_count_full, "complete flag mismatch")
	`FCIP_ASSERT_NXT(a_emit_shows, emit, res_valid, "frame end gave no result")
	`FCIP_ASSERT_NXT(a_emit_idle, emit, phase_q == PH_IDLE, "frame end left phase busy")
	`FCIP_ASSERT_IMP(a_emit_trailer, emit, (phase_q == PH_TRAILER) && rx_fire, "result outside trailer")

endmodule

// ===== design/fcip_token.sv =====
// ----------------------------------------------------------------------------
// fcip_token
// Per-byte decimal token decoder and six-entry value store.
// ----------------------------------------------------------------------------
module fcip_token
	import fcip_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  fcip_tok_ctl_t      ctl,
	input  logic [7:0]         data,
	output fcip_values_t       store_next,
	output logic [COUNT_W-1:0] count_next
);

	typedef enum logic [1:0] {
		TOK_NONE,
		TOK_LEAD,
		TOK_DIGITS,
		TOK_SKIP
	} tok_phase_t;

	tok_phase_t         phase_q, phase_n, phase_cur;
	logic               neg_q, neg_n;
	logic [VALUE_W-1:0] acc_q, acc_n, acc_x10;
	logic [COUNT_W-1:0] count_q;
	fcip_values_t       store_q;
	logic               digit, blank, commit;
	logic [3:0]         dval;

	assign digit   = (data >= CHAR_ZERO) && (data <= CHAR_NINE);
	assign blank   = (data == CHAR_SPACE) || ((data >= CHAR_TAB) && (data <= CHAR_CR));
	assign dval    = 4'(data - CHAR_ZERO);
	assign acc_x10 = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0}
		+ VALUE_W'(dval);

	always_comb begin
		phase_n    = phase_q;
		neg_n      = neg_q;
		acc_n      = acc_q;
		count_next = count_q;
		store_next = store_q;
		commit     = 1'b0;
		phase_cur  = (phase_q == TOK_NONE) ? TOK_LEAD : phase_q;
		if (ctl.clear) begin
			phase_n    = TOK_NONE;
			neg_n      = 1'b0;
			acc_n      = '0;
			count_next = '0;
		end else if ((ctl.feed && ctl.sep) || ctl.finish) begin
			commit = 1'b1;
		end else if (ctl.feed) begin
			case (phase_cur)
				TOK_LEAD: begin
					if (blank) begin
						phase_n = TOK_LEAD;
					end else if ((data == CHAR_PLUS) || (data == CHAR_MINUS)) begin
						neg_n   = (data == CHAR_MINUS);
						phase_n = TOK_DIGITS;
					end else if (digit) begin
						phase_n = TOK_DIGITS;
						acc_n   = acc_x10;
					end else begin
						phase_n = TOK_SKIP;
					end
				end
				TOK_DIGITS: begin
					if (digit) begin
						acc_n = acc_x10;
					end else begin
						phase_n = TOK_SKIP;
					end
				end
				default: phase_n = phase_cur;
			endcase
		end
		if (commit) begin
			if ((phase_q != TOK_NONE) && (count_q < COUNT_W'(VALUE_SLOTS))) begin
				store_next[count_q] = neg_q ? (VALUE_W'(0) - acc_q) : acc_q;
				count_next          = count_q + COUNT_W'(1);
			end
			phase_n = TOK_NONE;
			neg_n   = 1'b0;
			acc_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= TOK_NONE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			count_q <= '0;
			store_q <= '0;
		end else begin
			phase_q <= phase_n;
			neg_q   <= neg_n;
			acc_q   <= acc_n;
			count_q <= count_next;
			store_q <= store_next;
		end
	end

endmodule

// ===== design/fcip_out_queue.sv =====
// ----------------------------------------------------------------------------
// fcip_out_queue
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module fcip_out_queue
	import fcip_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  fcip_result_t push_data,
	output logic         full,
	output logic         out_valid,
	input  logic         out_ready,
	output fcip_result_t out_data
);

	logic         out_valid_q, skid_valid_q;
	fcip_result_t out_q, skid_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			// head is free this cycle: refill from skid first
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== dv/framed_csv_integer_parser_core_checker.sv =====
// ----------------------------------------------------------------------------
// framed_csv_integer_parser_core_checker
// Watches the byte, result and register ports of the frame parser, decodes
// every accepted byte into its own copy of frame and token state, queues the
// frame result it expects and compares each accepted result against the
// oldest one. Hands the mismatch count and the pending frame count upward.
// ----------------------------------------------------------------------------
module framed_csv_integer_parser_core_checker
	import fcip_pkg::*;
#(
	parameter int PAYLOAD_CAPACITY = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	input  logic                 rx_ready,
	input  logic [7:0]           rx_byte,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  logic [VALUE_W-1:0]   value_zero,
	input  logic [VALUE_W-1:0]   value_one,
	input  logic [VALUE_W-1:0]   value_two,
	input  logic [VALUE_W-1:0]   value_three,
	input  logic [VALUE_W-1:0]   value_four,
	input  logic [VALUE_W-1:0]   value_five,
	input  logic [COUNT_W-1:0]   tokens_found,
	input  logic                 complete,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int                   mismatches,
	output int                   frames_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		FRAME_IDLE,
		FRAME_PAYLOAD,
		FRAME_TRAILER
	} framing_t;

	typedef enum logic [1:0] {
		TOK_NONE,
		TOK_BLANK,
		TOK_DIGITS,
		TOK_REST
	} tok_state_t;

	logic [7:0]         start_code;
	logic [7:0]         first_end_code;
	logic [7:0]         second_end_code;
	logic [7:0]         separator_code;

	framing_t           framing;
	logic [7:0]         payload_bytes;
	logic               parse_halted;
	tok_state_t         tok_state;
	logic               tok_minus;
	logic [VALUE_W-1:0] tok_value;
	logic [COUNT_W-1:0] slots_used;
	fcip_values_t       slot_values;

	fcip_result_t       expected_frames[$];
	int                 frames_checked;

	task automatic log_failure(input string msg);
		$display("%0t ERROR: %s", $time, msg);
		mismatches++;
	endtask

	// Store an open token if a slot is free, then clear the token.
	task automatic close_token();
		if (tok_state != TOK_NONE && slots_used < VALUE_SLOTS) begin
			slot_values[slots_used] = tok_minus ? 16'd0 - tok_value : tok_value;
			slots_used = slots_used + 1'b1;
		end
		tok_state = TOK_NONE;
		tok_minus = 1'b0;
		tok_value = '0;
	endtask

	task automatic decode_rx_byte(input logic [7:0] c);
		logic         is_digit;
		logic         is_blank;
		logic         took_sign;
		fcip_result_t frame_out;
		is_digit  = (c >= CHAR_ZERO && c <= CHAR_NINE);
		is_blank  = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
		took_sign = 1'b0;
		case (framing)
			FRAME_IDLE: begin
				if (c == start_code) begin
					payload_bytes = '0;
					parse_halted  = 1'b0;
					tok_state     = TOK_NONE;
					tok_minus     = 1'b0;
					tok_value     = '0;
					slots_used    = '0;
					framing       = FRAME_PAYLOAD;
				end
			end
			FRAME_PAYLOAD: begin
				if (c == first_end_code) begin
					framing = FRAME_TRAILER;
				end else if (payload_bytes < PAYLOAD_CAPACITY) begin
					payload_bytes = payload_bytes + 8'd1;
					if (!parse_halted) begin
						if (c == CHAR_NUL) begin
							parse_halted = 1'b1;
						end else if (c == separator_code) begin
							close_token();
						end else begin
							if (tok_state == TOK_NONE)
								tok_state = TOK_BLANK;
							if (tok_state == TOK_BLANK && !is_blank) begin
								if (c == CHAR_PLUS || c == CHAR_MINUS) begin
									tok_minus = (c == CHAR_MINUS);
									tok_state = TOK_DIGITS;
									took_sign = 1'b1;
								end else begin
									tok_state = is_digit ? TOK_DIGITS : TOK_REST;
								end
							end
							// A sign byte carries no digit; digits wrap at 16 bits.
							if (tok_state == TOK_DIGITS && !took_sign) begin
								if (is_digit)
									tok_value = tok_value * 16'd10 + {8'd0, c - CHAR_ZERO};
								else
									tok_state = TOK_REST;
							end
						end
					end
				end
			end
			FRAME_TRAILER: begin
				if (c == second_end_code) begin
					close_token();
					framing                = FRAME_IDLE;
					frame_out.values       = slot_values;
					frame_out.tokens_found = slots_used;
					frame_out.complete     = (slots_used == VALUE_SLOTS);
					expected_frames.push_back(frame_out);
				end
			end
			default: begin
				framing = FRAME_IDLE;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		fcip_values_t got_vals;
		fcip_result_t want;
		if (!arst_n) begin
			start_code      = START_RST;
			first_end_code  = FIRST_END_RST;
			second_end_code = SECOND_END_RST;
			separator_code  = SEPARATOR_RST;
			framing         = FRAME_IDLE;
			payload_bytes   = '0;
			parse_halted    = 1'b0;
			tok_state       = TOK_NONE;
			tok_minus       = 1'b0;
			tok_value       = '0;
			slots_used      = '0;
			slot_values     = '0;
			expected_frames.delete();
			frames_checked  = 0;
			mismatches      = 0;
		end else begin
			// Check results before decoding: a result is registered behind its frame end, never alongside it.
			if (res_valid && res_ready) begin
				got_vals = {value_five, value_four, value_three, value_two, value_one,
					value_zero};
				if (expected_frames.size() == 0) begin
					log_failure($sformatf("result beat with no frame pending, tokens_found %0d",
						tokens_found));
				end else begin
					want = expected_frames.pop_front();
					for (int i = 0; i < VALUE_SLOTS; i++) begin
						if (got_vals[i] !== want.values[i])
							log_failure($sformatf("frame %0d value %0d: got %0d, want %0d",
								frames_checked, i, got_vals[i], want.values[i]));
					end
					if (tokens_found !== want.tokens_found)
						log_failure($sformatf("frame %0d tokens_found: got %0d, want %0d",
							frames_checked, tokens_found, want.tokens_found));
					if (complete !== want.complete)
						log_failure($sformatf("frame %0d complete: got %0b, want %0b",
							frames_checked, complete, want.complete));
					frames_checked++;
				end
			end
			// A byte on the same edge as a register write sees the old register.
			if (rx_valid && rx_ready)
				decode_rx_byte(rx_byte);
			if (cfg_we) begin
				case (cfg_index)
					REG_START:      start_code      = cfg_data;
					REG_FIRST_END:  first_end_code  = cfg_data;
					REG_SECOND_END: second_end_code = cfg_data;
					REG_SEPARATOR:  separator_code  = cfg_data;
					default: ;
				endcase
			end
		end
		frames_pending <= expected_frames.size();
	end

endmodule

// ===== dv/framed_csv_integer_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// framed_csv_integer_parser_core_tb
// Drives framed comma-separated byte streams into the parser under five
// framing-byte settings and four idle/stall mixes, including one long result
// hold-off that backs up the byte input. The checker beside the block
// predicts and compares every frame result; this module gives the verdict.
// ----------------------------------------------------------------------------
module framed_csv_integer_parser_core_tb
	import fcip_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         PAYLOAD_CAPACITY = 63;
	localparam int         HOLD_CYCLES      = 400;
	localparam int         LATENCY_CYCLES   = 4;
	localparam logic [7:0] CHAR_LOWER_X     = 8'h78;

	logic                 clk;
	logic                 arst_n;
	logic                 rx_valid;
	logic                 rx_ready;
	logic [7:0]           rx_byte;
	logic                 res_valid;
	logic                 res_ready;
	logic [VALUE_W-1:0]   value_zero;
	logic [VALUE_W-1:0]   value_one;
	logic [VALUE_W-1:0]   value_two;
	logic [VALUE_W-1:0]   value_three;
	logic [VALUE_W-1:0]   value_four;
	logic [VALUE_W-1:0]   value_five;
	logic [COUNT_W-1:0]   tokens_found;
	logic                 complete;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	int                   mismatches;
	int                   frames_pending;

	int                   idle_pct;
	int                   stall_pct;
	int                   hold_tag;
	int                   bytes_sent;
	logic [7:0]           cur_start;
	logic [7:0]           cur_first_end;
	logic [7:0]           cur_second_end;
	logic [7:0]           cur_separator;

	// Stray byte, " -1,,99999" with trailer noise and a start byte in the wait,
	// then "+5" with a start byte and a NUL in the payload.
	logic [7:0] directed_bytes[$] = '{
		CHAR_LOWER_X,
		START_RST, CHAR_SPACE, CHAR_MINUS, CHAR_ZERO + 8'd1, SEPARATOR_RST, SEPARATOR_RST,
		CHAR_NINE, CHAR_NINE, CHAR_NINE, CHAR_NINE, CHAR_NINE,
		FIRST_END_RST, CHAR_LOWER_X, START_RST, SECOND_END_RST,
		START_RST, CHAR_PLUS, CHAR_ZERO + 8'd5, START_RST, CHAR_NUL, SEPARATOR_RST,
		CHAR_ZERO + 8'd7, FIRST_END_RST, SECOND_END_RST
	};

	framed_csv_integer_parser_core #(
		.PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
	) u_dut (.*);

	framed_csv_integer_parser_core_checker #(
		.PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
	) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("framed_csv_integer_parser_core verification failed");
		$finish;
	end

	// Result side: random stalls, or a long hold-off each time hold_tag moves.
	initial begin
		int seen_tag;
		int hold_left;
		res_ready = 1'b0;
		seen_tag  = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_tag != seen_tag) begin
				seen_tag  = hold_tag;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Keep payload bytes off the first end byte so every frame closes cleanly.
	task automatic send_payload(input logic [7:0] b);
		while (b == cur_first_end)
			b = 8'($urandom_range(255));
		send_byte(b);
	endtask

	task automatic send_frame();
		int         n_stray;
		int         n_tok;
		int         n_blank;
		int         n_digit;
		int         n_noise;
		int         sign_pick;
		logic [7:0] b;
		n_stray = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n_stray) begin
			b = 8'($urandom_range(255));
			if (b == cur_start)
				b = ~b;
			send_byte(b);
		end
		send_byte(cur_start);
		n_tok = ($urandom_range(9) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 6);
		for (int k = 0; k < n_tok; k++) begin
			if (k > 0 && cur_separator != cur_first_end) begin
				send_payload(cur_separator);
				if ($urandom_range(7) == 0)
					send_payload(cur_separator);
			end
			if ($urandom_range(14) == 0)
				send_payload(CHAR_NUL);
			if ($urandom_range(14) == 0)
				send_payload(cur_start);
			n_blank = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
			repeat (n_blank)
				send_payload(($urandom_range(4) == 0) ? CHAR_SPACE :
					8'($urandom_range(CHAR_TAB, CHAR_CR)));
			sign_pick = $urandom_range(3);
			if (sign_pick == 0)
				send_payload(CHAR_PLUS);
			else if (sign_pick == 1)
				send_payload(CHAR_MINUS);
			n_digit = ($urandom_range(7) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
			repeat (n_digit)
				send_payload(CHAR_ZERO + 8'($urandom_range(9)));
			if ($urandom_range(5) == 0)
				send_payload(8'($urandom_range(255)));
		end
		// Run past the payload capacity now and then.
		if ($urandom_range(24) == 0) begin
			repeat ($urandom_range(40, 90))
				send_payload(8'($urandom_range(255)));
		end
		send_byte(cur_first_end);
		n_noise = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n_noise) begin
			b = 8'($urandom_range(255));
			if (b == cur_second_end)
				b = ~b;
			send_byte(b);
		end
		if ($urandom_range(9) == 0 && cur_start != cur_second_end)
			send_byte(cur_start);
		send_byte(cur_second_end);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic program_framing(input logic [7:0] s, input logic [7:0] f,
		input logic [7:0] e, input logic [7:0] p);
		write_reg(REG_START, s);
		write_reg(REG_FIRST_END, f);
		write_reg(REG_SECOND_END, e);
		write_reg(REG_SEPARATOR, p);
		cfg_we         <= 1'b0;
		cur_start      = s;
		cur_first_end  = f;
		cur_second_end = e;
		cur_separator  = p;
	endtask

	// Drain: the pending count is registered, so wait for a clock edge before polling it.
	task automatic settle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (frames_pending != 0)
			@(posedge clk);
		repeat (LATENCY_CYCLES)
			@(posedge clk);
	endtask

	task automatic run_phase(input int target);
		while (bytes_sent < target)
			send_frame();
		settle();
		bytes_sent = 0;
	endtask

	initial begin
		logic [7:0] rnd_start;
		logic [7:0] rnd_first_end;
		logic [7:0] rnd_second_end;
		logic [7:0] rnd_separator;
		arst_n         = 1'b0;
		rx_valid       = 1'b0;
		rx_byte        = '0;
		cfg_we         = 1'b0;
		cfg_index      = REG_START;
		cfg_data       = '0;
		idle_pct       = 0;
		stall_pct      = 0;
		hold_tag       = 0;
		bytes_sent     = 0;
		cur_start      = START_RST;
		cur_first_end  = FIRST_END_RST;
		cur_second_end = SECOND_END_RST;
		cur_separator  = SEPARATOR_RST;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults, full rate; hold off results while bytes keep coming.
		foreach (directed_bytes[k])
			send_byte(directed_bytes[k]);
		hold_tag++;
		run_phase(400);

		idle_pct  = 83;
		stall_pct = 0;
		program_framing(8'hFF, 8'h00, 8'hFF, 8'h3B);
		run_phase(400);

		idle_pct  = 0;
		stall_pct = 83;
		program_framing(8'h00, 8'h7E, 8'h00, 8'hFF);
		run_phase(400);

		idle_pct  = 26;
		stall_pct = 26;
		rnd_start      = 8'($urandom_range(255));
		rnd_second_end = 8'($urandom_range(255));
		do
			rnd_first_end = 8'($urandom_range(255));
		while (rnd_first_end == rnd_start || rnd_first_end inside {[CHAR_ZERO:CHAR_NINE]});
		do
			rnd_separator = 8'($urandom_range(255));
		while (rnd_separator == rnd_first_end || rnd_separator inside {[CHAR_ZERO:CHAR_NINE]});
		program_framing(rnd_start, rnd_first_end, rnd_second_end, rnd_separator);
		run_phase(400);

		// Separator equal to the first end byte, second end equal to start.
		program_framing(8'h2A, 8'h2F, 8'h2A, 8'h2F);
		run_phase(80);

		if (mismatches == 0)
			$display("framed_csv_integer_parser_core verification clean");
		else
			$display("framed_csv_integer_parser_core verification failed");
		$finish;
	end

endmodule
